// File: rtl/toc_format0_parse_check_defines.svh
// Assertion macros used by the port-level checker of the TOC format 0 checker.
`ifndef TOC_FORMAT0_PARSE_CHECK_DEFINES_SVH
`define TOC_FORMAT0_PARSE_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked while rst is high.
`define TOC0_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and masked while rst is high.
`define TOC0_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TOC0_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/toc0_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc0_pkg
// Types and constants shared by the TOC format 0 reply checker.
// ----------------------------------------------------------------------------
package toc0_pkg;

  localparam int POS_W      = 17;
  localparam int DESC_W     = 48;
  localparam int MAX_TRACKS = 99;

  localparam logic [7:0] LEADOUT_CODE = 8'hAA;
  localparam logic [7:0] TRACK_LIMIT  = 8'd99;
  localparam logic [2:0] DESC_ALIGN   = 3'd4;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  track_number;
    logic [3:0]  adr_field;
    logic [3:0]  control_field;
    logic [31:0] start_block;
    logic [7:0]  first_declared;
    logic [7:0]  last_declared;
    logic [6:0]  entry_count;
    logic        leadout_seen;
    logic [31:0] leadout_block;
    logic        table_valid;
    logic        last_of_run;
  } result_t;

  // Work handed from the byte parser to the descriptor checker.
  typedef struct packed {
    logic              has_desc;
    logic [DESC_W-1:0] desc;
    logic              has_end;
    logic              span_ok;
    logic [7:0]        first_declared;
    logic [7:0]        last_declared;
  } cmd_t;

endpackage

// File: rtl/toc0_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc0_front
// Byte parser: tracks position and span, gathers descriptors, flags run end.
// ----------------------------------------------------------------------------
module toc0_front (
  input  logic            clk,
  input  logic            rst,
  input  toc0_pkg::item_t item,
  input  logic            take,
  output toc0_pkg::cmd_t  cmd,
  output logic            cmd_valid
);
  import toc0_pkg::*;

  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  claimed, claimed_next;
  logic [POS_W-1:0]  span;
  logic [7:0]        hdr_first, hdr_first_next;
  logic [7:0]        hdr_last, hdr_last_next;
  logic [DESC_W-1:0] shift, shift_next;
  logic [2:0]        off;
  logic              desc_done;
  logic              span_ge4;

  always_comb begin
    claimed_next   = claimed;
    hdr_first_next = hdr_first;
    hdr_last_next  = hdr_last;
    shift_next     = shift;
    desc_done      = 1'b0;
    // Offset inside the current 8-byte descriptor; body starts at byte 4.
    off = pos[2:0] + DESC_ALIGN;
    if (pos == POS_W'(0)) begin
      claimed_next = {1'b0, item.data_byte, 8'h00};
    end else if (pos == POS_W'(1)) begin
      claimed_next = claimed + {{(POS_W-8){1'b0}}, item.data_byte} + POS_W'(2);
    end else if (pos == POS_W'(2)) begin
      hdr_first_next = item.data_byte;
    end else if (pos == POS_W'(3)) begin
      hdr_last_next = item.data_byte;
    end else if (pos < claimed) begin
      // Bytes 0 and 3 of a descriptor are reserved and not kept.
      if (off != 3'd0 && off != 3'd3) begin
        shift_next = {shift[DESC_W-9:0], item.data_byte};
      end
      desc_done = (off == 3'd7);
    end
    pos_next = (pos == {POS_W{1'b1}}) ? pos : pos + POS_W'(1);

    if (pos_next < POS_W'(4)) begin
      span = '0;
    end else if (claimed_next < pos_next) begin
      span = claimed_next;
    end else begin
      span = pos_next;
    end
    span_ge4 = (span >= POS_W'(4));

    cmd.has_desc       = desc_done;
    cmd.desc           = shift_next;
    cmd.has_end        = item.end_of_buffer;
    cmd.span_ok        = span_ge4 && (span[2:0] == DESC_ALIGN);
    cmd.first_declared = span_ge4 ? hdr_first_next : 8'h00;
    cmd.last_declared  = span_ge4 ? hdr_last_next : 8'h00;
    cmd_valid          = take && (desc_done || item.end_of_buffer);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_buffer)) begin
      pos       <= '0;
      claimed   <= '0;
      hdr_first <= '0;
      hdr_last  <= '0;
      shift     <= '0;
    end else if (take) begin
      pos       <= pos_next;
      claimed   <= claimed_next;
      hdr_first <= hdr_first_next;
      hdr_last  <= hdr_last_next;
      shift     <= shift_next;
    end
  end

endmodule

// File: rtl/toc0_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc0_cmd_queue
// Two-entry queue between the byte parser and the descriptor checker.
// ----------------------------------------------------------------------------
module toc0_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  toc0_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output toc0_pkg::cmd_t rd_data,
  output logic           q_full,
  output logic           q_empty
);
  import toc0_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// File: rtl/toc0_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc0_back
// Descriptor checker: validates track entries and builds the run verdict.
// ----------------------------------------------------------------------------
module toc0_back (
  input  logic              clk,
  input  logic              rst,
  input  toc0_pkg::cmd_t    cmd,
  input  logic              cmd_avail,
  input  logic              res_room,
  output logic              cmd_take,
  output toc0_pkg::result_t res0,
  output toc0_pkg::result_t res1,
  output logic [1:0]        res_count
);
  import toc0_pkg::*;

  logic [6:0]  prev_trk, prev_trk_next;
  logic [6:0]  opening_trk, opening_trk_next;
  logic [6:0]  count, count_next;
  logic        lo_flag, lo_flag_next;
  logic [31:0] lo_start, lo_start_next;
  logic        err, err_next;

  logic [7:0]  adr_ctl;
  logic [7:0]  trk;
  logic [31:0] lba;
  logic        entry_ok;
  logic        ok;
  logic [7:0]  hf;
  logic [7:0]  hl;
  logic [7:0]  want_count;
  result_t     entry;
  result_t     verdict;

  assign cmd_take = cmd_avail && res_room;

  always_comb begin
    adr_ctl = cmd.desc[47:40];
    trk     = cmd.desc[39:32];
    lba     = cmd.desc[31:0];

    prev_trk_next    = prev_trk;
    opening_trk_next = opening_trk;
    count_next       = count;
    lo_flag_next     = lo_flag;
    lo_start_next    = lo_start;
    err_next         = err;
    entry_ok         = 1'b0;

    if (cmd.has_desc && !err) begin
      if (trk == LEADOUT_CODE) begin
        if (lo_flag) begin
          err_next = 1'b1;
        end else begin
          lo_flag_next  = 1'b1;
          lo_start_next = lba;
        end
      end else if (trk == 8'h00 || trk > TRACK_LIMIT || lo_flag ||
                   trk <= {1'b0, prev_trk} || count >= 7'(MAX_TRACKS)) begin
        err_next = 1'b1;
      end else begin
        entry_ok = 1'b1;
        if (count == 7'd0) begin
          opening_trk_next = trk[6:0];
        end
        count_next    = count + 7'd1;
        prev_trk_next = trk[6:0];
      end
    end

    // Header checks see the state as it stands after this descriptor.
    hf         = cmd.first_declared;
    hl         = cmd.last_declared;
    want_count = hl - hf + 8'd1;
    ok         = cmd.span_ok && !err_next;
    if (hf == 8'h00 || hf > TRACK_LIMIT) begin
      ok = 1'b0;
    end else if (hl < hf || hl > TRACK_LIMIT) begin
      ok = 1'b0;
    end else if ({1'b0, count_next} != want_count) begin
      ok = 1'b0;
    end else if ({1'b0, opening_trk_next} != hf || {1'b0, prev_trk_next} != hl) begin
      ok = 1'b0;
    end

    entry               = '0;
    entry.kind          = KIND_ENTRY;
    entry.track_number  = trk[6:0];
    entry.adr_field     = adr_ctl[7:4];
    entry.control_field = adr_ctl[3:0];
    entry.start_block   = lba;

    verdict                = '0;
    verdict.kind           = KIND_VERDICT;
    verdict.first_declared = hf;
    verdict.last_declared  = hl;
    verdict.entry_count    = count_next;
    verdict.leadout_seen   = lo_flag_next;
    verdict.leadout_block  = lo_start_next;
    verdict.table_valid    = ok;
    verdict.last_of_run    = 1'b1;

    res0 = entry_ok ? entry : verdict;
    res1 = verdict;
    if (!cmd_take) begin
      res_count = 2'd0;
    end else begin
      res_count = {1'b0, entry_ok} + {1'b0, cmd.has_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd_take && cmd.has_end)) begin
      prev_trk    <= '0;
      opening_trk <= '0;
      count       <= '0;
      lo_flag     <= 1'b0;
      lo_start    <= '0;
      err         <= 1'b0;
    end else if (cmd_take) begin
      prev_trk    <= prev_trk_next;
      opening_trk <= opening_trk_next;
      count       <= count_next;
      lo_flag     <= lo_flag_next;
      lo_start    <= lo_start_next;
      err         <= err_next;
    end
  end

endmodule

// File: rtl/toc0_res_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc0_res_queue
// Four-entry result queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module toc0_res_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        wr_count,
  input  toc0_pkg::result_t wr0,
  input  toc0_pkg::result_t wr1,
  input  logic              rd_en,
  output toc0_pkg::result_t rd_data,
  output logic              q_empty,
  output logic              room2
);
  import toc0_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign q_empty = (count == 3'd0);
  assign room2   = (count <= 3'd2);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wr_count;
      if (rd_en) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, wr_count} - {2'b00, rd_en};
    end
  end

endmodule

// File: rtl/toc_format0_parse_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc_format0_parse_check
// Streaming checker for READ TOC format 0 reply buffers.
// ----------------------------------------------------------------------------
// Bytes of one reply are pushed one per cycle, with end_of_buffer on the last
// byte; the block takes one byte per clock while full is low. A parser tracks
// position, span and header and assembles descriptors; each finished descriptor
// or end of buffer goes through a two-entry command queue to a checker that
// validates track entries, emits one result per accepted track and one verdict
// per run. Results wait in a four-entry queue; a result is registered in the
// command queue and then in the result queue before it reaches the result ports.
// The checker takes a command only while two result slots are free, so full
// rises when the consumer stops popping for a while.
module toc_format0_parse_check (
  input  logic              clk,
  input  logic              rst,
  input  toc0_pkg::item_t   item,
  input  logic              push,
  output logic              full,
  output toc0_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import toc0_pkg::*;

  logic       take;
  cmd_t       front_cmd;
  logic       front_valid;
  cmd_t       head_cmd;
  logic       cmd_empty;
  logic       cmd_take;
  logic       res_room;
  result_t    res0;
  result_t    res1;
  logic [1:0] res_count;

  assign take = push && !full;

  toc0_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (take),
    .cmd       (front_cmd),
    .cmd_valid (front_valid)
  );

  toc0_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .rd_en   (cmd_take),
    .rd_data (head_cmd),
    .q_full  (full),
    .q_empty (cmd_empty)
  );

  toc0_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_avail (!cmd_empty),
    .res_room  (res_room),
    .cmd_take  (cmd_take),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  toc0_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_count (res_count),
    .wr0      (res0),
    .wr1      (res1),
    .rd_en    (pop && !empty),
    .rd_data  (result),
    .q_empty  (empty),
    .room2    (res_room)
  );

endmodule

// File: rtl/toc0_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc0_checker
// Port-level assertions for the TOC format 0 checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "toc_format0_parse_check_defines.svh"

module toc0_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input toc0_pkg::result_t result,
  input logic              empty,
  input logic              pop
);
  import toc0_pkg::*;

  logic show_entry;
  logic show_valid;
  logic track_legal;
  logic header_sane;

  assign show_entry  = !empty && result.kind == KIND_ENTRY;
  assign show_valid  = !empty && result.kind == KIND_VERDICT && result.table_valid;
  assign track_legal = result.track_number != 7'd0 && result.track_number <= 7'd99;
  assign header_sane = result.entry_count != 7'd0 && result.first_declared != 8'd0 &&
                       result.first_declared <= result.last_declared;

  // Both queues come out of reset with nothing in them.
  `TOC0_ASSERT_RESET(a_reset_clear, rst, empty && !full, "queues not clear after reset")

  // Only a verdict closes a run.
  `TOC0_ASSERT_NOW(a_run_end, !empty, result.last_of_run == result.kind, "last_of_run mismatch")

  // Track entries carry a legal track number.
  `TOC0_ASSERT_NOW(a_entry_track, show_entry, track_legal, "entry track out of range")

  // A valid verdict has at least one track and a sane header.
  `TOC0_ASSERT_NOW(a_valid_verdict, show_valid, header_sane, "valid verdict with bad header")

  // A result that is not taken stays in place.
  `TOC0_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result changed")

endmodule

bind toc_format0_parse_check toc0_checker u_toc0_checker (.*);

// File: tb/sv/tb_toc_format0_parse_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toc_format0_parse_check
// Self-checking bench for the streaming TOC format 0 reply checker.
// ----------------------------------------------------------------------------
// A short scripted set of replies covers the short-buffer, partial-descriptor
// and extreme-value corners, with hand-written verdicts. Randomly built TOC
// replies follow, most of them well formed and the rest damaged: bad track
// bytes, wrong lengths, truncation, trailing bytes, bad headers, misplaced
// lead-outs, gaps and plain noise. A byte-level predictor follows every
// accepted byte and queues the track entries and verdicts it expects; each
// popped result is compared field by field in order. Both sides idle at
// random in the first two phases and never in the third, where the reader is
// once held off so that the input stalls while a full 99-track table streams in.
module tb_toc_format0_parse_check;
  import toc0_pkg::*;

  typedef enum int {
    FLAW_NONE,
    FLAW_TRACK_BYTE,
    FLAW_LENGTH,
    FLAW_TRUNCATE,
    FLAW_TRAILING,
    FLAW_HEADER,
    FLAW_LEADOUT,
    FLAW_GAP,
    FLAW_NOISE
  } flaw_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       typed;
    logic [7:0] want_first;
    logic [7:0] want_last;
    logic [6:0] want_count;
    logic       want_valid;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;

  logic    clk;
  logic    rst;
  item_t   item;
  logic    push;
  logic    full;
  result_t result;
  logic    empty;
  logic    pop;

  // Scripted replies; rows with typed set carry the verdict expected on that byte.
  script_row_t toc_script [SCRIPT_LEN] = '{
    // One byte alone cannot hold a header.
    '{8'h00, 1'b1, 1'b1, 8'd0, 8'd0, 7'd0, 1'b0},
    // Three bytes of all ones are still too short.
    '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'd0, 8'd0, 7'd0, 1'b0},
    // Header only: the shape is fine, but no track matches it.
    '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h02, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b1, 1'b1, 8'd1, 8'd1, 7'd0, 1'b0},
    // One byte past the header leaves a partial descriptor.
    '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h03, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 8'd1, 8'd1, 7'd0, 1'b0},
    // A single track at the highest start block, without a lead-out.
    '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h0A, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'd1, 8'd1, 7'd1, 1'b1}
  };

  // Predictor state for the reply being parsed.
  logic [POS_W-1:0]  bytes_in;
  logic [POS_W-1:0]  claim_len;
  logic [7:0]        decl_first;
  logic [7:0]        decl_last;
  logic [DESC_W-1:0] desc_bytes;
  logic [6:0]        newest_track;
  logic [6:0]        opening_track;
  logic [6:0]        tracks_taken;
  logic              leadout_hit;
  logic [31:0]       leadout_addr;
  logic              toc_broken;

  result_t    results_due [$];
  logic [7:0] reply_bytes [$];

  int send_idle_pct = 36;
  int recv_idle_pct = 84;
  int hold_request  = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int entries_seen = 0;
  int good_tables = 0;
  int bad_tables = 0;

  toc_format0_parse_check dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void clear_toc_state();
    bytes_in      = '0;
    claim_len     = '0;
    decl_first    = '0;
    decl_last     = '0;
    desc_bytes    = '0;
    newest_track  = '0;
    opening_track = '0;
    tracks_taken  = '0;
    leadout_hit   = 1'b0;
    leadout_addr  = '0;
    toc_broken    = 1'b0;
  endfunction

  function automatic void judge_descriptor();
    logic [7:0] ctl;
    logic [7:0] trk;
    result_t    entry;
    ctl = desc_bytes[47:40];
    trk = desc_bytes[39:32];
    if (toc_broken) return;
    if (trk == LEADOUT_CODE) begin
      // Only one lead-out is allowed in a table.
      if (leadout_hit) begin
        toc_broken = 1'b1;
      end else begin
        leadout_hit = 1'b1;
        leadout_addr = desc_bytes[31:0];
      end
      return;
    end
    if (trk == 8'd0 || trk > TRACK_LIMIT || leadout_hit || trk <= {1'b0, newest_track} ||
        tracks_taken >= 7'(MAX_TRACKS)) begin
      toc_broken = 1'b1;
      return;
    end
    if (tracks_taken == 7'd0) opening_track = trk[6:0];
    tracks_taken = tracks_taken + 7'd1;
    newest_track = trk[6:0];
    entry = '0;
    entry.kind = KIND_ENTRY;
    entry.track_number = trk[6:0];
    entry.adr_field = ctl[7:4];
    entry.control_field = ctl[3:0];
    entry.start_block = desc_bytes[31:0];
    results_due.push_back(entry);
  endfunction

  function automatic void parse_toc_byte(logic [7:0] b, logic eob);
    logic [POS_W-1:0] span;
    logic [2:0]       slot;
    logic             ok;
    result_t          verdict;
    if (bytes_in == 0) begin
      claim_len = {1'b0, b, 8'h00};
    end else if (bytes_in == 1) begin
      claim_len = (claim_len | {9'd0, b}) + 17'd2;
    end else if (bytes_in == 2) begin
      decl_first = b;
    end else if (bytes_in == 3) begin
      decl_last = b;
    end else if (bytes_in < claim_len) begin
      // Descriptor bytes 0 and 3 are reserved and never kept.
      slot = bytes_in[2:0] - DESC_ALIGN;
      if (slot != 3'd0 && slot != 3'd3) desc_bytes = {desc_bytes[DESC_W-9:0], b};
      if (slot == 3'd7) judge_descriptor();
    end
    if (bytes_in != '1) bytes_in = bytes_in + 1'b1;
    if (eob) begin
      span = (bytes_in < 4) ? '0 : ((claim_len < bytes_in) ? claim_len : bytes_in);
      ok = (span >= 4);
      verdict = '0;
      verdict.kind = KIND_VERDICT;
      if (ok) begin
        verdict.first_declared = decl_first;
        verdict.last_declared = decl_last;
      end
      // The span has to be the header plus whole descriptors.
      if (span[2:0] != DESC_ALIGN || toc_broken) ok = 1'b0;
      else if (decl_first == 8'd0 || decl_first > TRACK_LIMIT) ok = 1'b0;
      else if (decl_last < decl_first || decl_last > TRACK_LIMIT) ok = 1'b0;
      else if (int'(tracks_taken) != int'(decl_last) - int'(decl_first) + 1) ok = 1'b0;
      else if ({1'b0, opening_track} != decl_first || {1'b0, newest_track} != decl_last)
        ok = 1'b0;
      verdict.entry_count = tracks_taken;
      verdict.leadout_seen = leadout_hit;
      verdict.leadout_block = leadout_addr;
      verdict.table_valid = ok;
      verdict.last_of_run = 1'b1;
      results_due.push_back(verdict);
      clear_toc_state();
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    string   diff;
    if (results_due.size() == 0) begin
      note_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = results_due.pop_front();
    diff = "";
    if (got.kind !== want.kind)
      diff = {diff, $sformatf(" kind %0d/%0d", want.kind, got.kind)};
    if (got.track_number !== want.track_number)
      diff = {diff, $sformatf(" track %0d/%0d", want.track_number, got.track_number)};
    if (got.adr_field !== want.adr_field)
      diff = {diff, $sformatf(" adr %h/%h", want.adr_field, got.adr_field)};
    if (got.control_field !== want.control_field)
      diff = {diff, $sformatf(" control %h/%h", want.control_field, got.control_field)};
    if (got.start_block !== want.start_block)
      diff = {diff, $sformatf(" start %h/%h", want.start_block, got.start_block)};
    if (got.first_declared !== want.first_declared)
      diff = {diff, $sformatf(" first %0d/%0d", want.first_declared, got.first_declared)};
    if (got.last_declared !== want.last_declared)
      diff = {diff, $sformatf(" last %0d/%0d", want.last_declared, got.last_declared)};
    if (got.entry_count !== want.entry_count)
      diff = {diff, $sformatf(" count %0d/%0d", want.entry_count, got.entry_count)};
    if (got.leadout_seen !== want.leadout_seen)
      diff = {diff, $sformatf(" leadout %0d/%0d", want.leadout_seen, got.leadout_seen)};
    if (got.leadout_block !== want.leadout_block)
      diff = {diff, $sformatf(" leadout_addr %h/%h", want.leadout_block, got.leadout_block)};
    if (got.table_valid !== want.table_valid)
      diff = {diff, $sformatf(" valid %0d/%0d", want.table_valid, got.table_valid)};
    if (got.last_of_run !== want.last_of_run)
      diff = {diff, $sformatf(" last_of_run %0d/%0d", want.last_of_run, got.last_of_run)};
    if (diff != "") begin
      note_mismatch({"fields differ (expected/actual):", diff});
    end else if (want.kind == KIND_ENTRY) begin
      entries_seen++;
    end else if (want.table_valid) begin
      good_tables++;
    end else begin
      bad_tables++;
    end
  endfunction

  function automatic void add_descriptor(logic [7:0] trk);
    reply_bytes.push_back(8'($urandom));
    reply_bytes.push_back(8'($urandom));
    reply_bytes.push_back(trk);
    repeat (5) reply_bytes.push_back(8'($urandom));
  endfunction

  // Builds one reply in reply_bytes: a consistent table, then the chosen damage, or plain noise.
  function automatic void build_toc(int n_tracks, flaw_t flaw);
    int          first_trk;
    int          trk;
    int          lo_at;
    int          cut;
    int          ndesc;
    logic [15:0] len;
    reply_bytes.delete();
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(40, 1)) reply_bytes.push_back(8'($urandom));
      return;
    end
    first_trk = $urandom_range(100 - ((n_tracks > 0) ? n_tracks : 1), 1);
    trk = first_trk;
    if (flaw == FLAW_LEADOUT) lo_at = $urandom_range(n_tracks);
    else if ($urandom_range(7) == 0) lo_at = -1;
    else lo_at = n_tracks;
    reply_bytes = '{8'h00, 8'h00, 8'(first_trk), 8'(first_trk + n_tracks - 1)};
    for (int i = 0; i <= n_tracks; i++) begin
      if (i == lo_at) add_descriptor(LEADOUT_CODE);
      if (i < n_tracks) begin
        add_descriptor(8'(trk));
        trk += (flaw == FLAW_GAP && $urandom_range(1) == 1) ? 2 : 1;
      end
    end
    if (flaw == FLAW_LEADOUT && $urandom_range(1) == 1) add_descriptor(LEADOUT_CODE);
    len = 16'(reply_bytes.size() - 2);
    case (flaw)
      FLAW_TRACK_BYTE: begin
        ndesc = (reply_bytes.size() - 4) / 8;
        if (ndesc > 0) reply_bytes[4 + 8 * $urandom_range(ndesc - 1) + 2] = 8'($urandom);
      end
      FLAW_LENGTH: begin
        if ($urandom_range(1) == 1) len = 16'($urandom);
        else len = 16'(int'(len) + int'($urandom_range(8)) - 4);
      end
      FLAW_TRUNCATE: begin
        cut = $urandom_range(reply_bytes.size() - 1, 1);
        while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
      end
      FLAW_TRAILING: begin
        repeat ($urandom_range(12, 1)) reply_bytes.push_back(8'($urandom));
      end
      FLAW_HEADER: begin
        reply_bytes[2 + $urandom_range(1)] = 8'($urandom);
      end
      default: ;
    endcase
    if (reply_bytes.size() > 0) reply_bytes[0] = len[15:8];
    if (reply_bytes.size() > 1) reply_bytes[1] = len[7:0];
  endfunction

  // Offers one byte from a falling edge and returns at the falling edge after its transfer.
  task automatic send_byte(input logic [7:0] b, input logic eob, input logic typed,
                           input result_t typed_want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, end_of_buffer: eob};
    do @(posedge clk); while (full);
    parse_toc_byte(b, eob);
    if (typed) results_due[$] = typed_want;
    bytes_sent++;
    if (eob) buffers_sent++;
    @(negedge clk);
  endtask

  task automatic send_reply();
    foreach (reply_bytes[i])
      send_byte(reply_bytes[i], i == reply_bytes.size() - 1, 1'b0, '0);
  endtask

  // Result side: random pops, with one long hold-off on request.
  initial begin
    int hold;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
        pop <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_result(result);
  end

  initial begin
    int      phase;
    int      phase_bytes;
    int      waited;
    int      n_tracks;
    flaw_t   flaw;
    result_t typed_want;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    clear_toc_state();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (toc_script[i]) begin
      typed_want = '0;
      typed_want.kind = KIND_VERDICT;
      typed_want.first_declared = toc_script[i].want_first;
      typed_want.last_declared = toc_script[i].want_last;
      typed_want.entry_count = toc_script[i].want_count;
      typed_want.table_valid = toc_script[i].want_valid;
      typed_want.last_of_run = 1'b1;
      send_byte(toc_script[i].data_byte, toc_script[i].last_byte, toc_script[i].typed,
                typed_want);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 36 : 0;
      if (phase == 2) begin
        // The reader stalls while a full 99-track table streams in, so the
        // result queue fills and back-pressure reaches the input.
        hold_request = 300;
        build_toc(MAX_TRACKS, FLAW_NONE);
        send_reply();
      end
      phase_bytes = 0;
      while (phase_bytes < 150) begin
        flaw = ($urandom_range(99) < 58) ? FLAW_NONE : flaw_t'(1 + $urandom_range(7));
        n_tracks = ($urandom_range(24) == 0) ? $urandom_range(16, 7) : $urandom_range(6);
        build_toc(n_tracks, flaw);
        send_reply();
        phase_bytes += reply_bytes.size();
      end
      push <= 1'b0;
      waited = 0;
      while (results_due.size() != 0 && waited < 20000) begin
        @(posedge clk);
        waited++;
      end
      @(negedge clk);
    end

    repeat (16) @(posedge clk);
    if (results_due.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
    $display("Sent %0d reply buffers in %0d bytes under three idling mixes.",
             buffers_sent, bytes_sent);
    $display("Checked %0d track entries, %0d valid and %0d rejected tables; %0d mismatches.",
             entries_seen, good_tables, bad_tables, mismatch_count);
    if (mismatch_count == 0) begin
      $display("toc_format0_parse_check: match");
    end else begin
      $display("toc_format0_parse_check: mismatch");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timeout with %0d results still expected.", results_due.size());
    $display("toc_format0_parse_check: mismatch");
    $finish;
  end

endmodule
